// ----- design/frn_pkg.sv -----
// ----------------------------------------------------------------------------
// frn_pkg: shared types and constants of the frame rate negotiator
// Field widths, mode codes, fixed-point constants and the control bundles
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package frn_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int START_RATE = 15;

    localparam int CLIENT_W  = 14;
    localparam int RATE_W    = 4;
    localparam int MARGIN_W  = 8;
    localparam int BITRATE_W = 31;
    localparam int COUNT_W   = 32;
    localparam int ACC_W     = 40;
    localparam int DIVD_W    = 22;
    localparam int DIVS_W    = 14;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic [1:0] MODE_RECEIVE = 2'd0;
    localparam logic [1:0] MODE_BUILD   = 2'd1;
    localparam logic [1:0] MODE_FRAME   = 2'd2;
    localparam logic [1:0] MODE_RESET   = 2'd3;

    localparam logic [1:0] CHANGE_DOWN = 2'd1;
    localparam logic [1:0] CHANGE_UP   = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_CLIENT_FPS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_OWN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CEILING    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FLOOR      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MARGIN     = 3'd4;

    localparam logic [CLIENT_W-1:0] CLIENT_RESET = CLIENT_W'(START_RATE << FRAC_BITS);
    localparam logic [CLIENT_W:0]   TENTH_Q      = (CLIENT_W+1)'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [BITRATE_W-1:0] BITRATE_MAX = {BITRATE_W{1'b1}};
    localparam logic [29:0]         RECIP_FIVE   = 30'h33333334;

    typedef struct packed {
        logic load;
        logic exec;
        logic scale;
        logic fc_first;
        logic fc_index;
        logic out_load;
    } frn_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } frn_status_t;

endpackage

// ----- design/frn_div.sv -----
// ----------------------------------------------------------------------------
// frn_div: restoring divider
// Unsigned divide of a 22-bit dividend by a 14-bit divisor, one quotient bit
// per cycle; done pulses when the quotient is complete.
// ----------------------------------------------------------------------------
module frn_div
    import frn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVS_W:0]   rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVS_W:0]   trial;
    logic [DIVS_W+1:0] diff;

    assign trial = {rem_reg[DIVS_W-1:0], quo_reg[DIVD_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVS_W+1])
            begin
                rem_reg <= diff[DIVS_W:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- design/frn_ctrl.sv -----
// ----------------------------------------------------------------------------
// frn_ctrl: sequencing controller
// Steps one item through execute and then scale, or divide and frame
// index phases, and keeps the output item valid until it is taken.
// ----------------------------------------------------------------------------
module frn_ctrl
    import frn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  frn_status_t status,
    output frn_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_FC1   = 3'd3;
    localparam logic [2:0] S_FC2   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.need_div ? S_DIV : S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_FC1;
                end
            end
            S_FC1:
            begin
                cmd.fc_first = 1'b1;
                state_next   = S_FC2;
            end
            S_FC2:
            begin
                cmd.fc_index = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_load_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EXEC)
        else $error("accepted item did not enter execute");
    a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("output item not presented after load");
    a_div_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && status.div_done) |=> state_reg != S_DIV)
        else $error("divide phase did not end on done");
    a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.scale, cmd.fc_first, cmd.fc_index,
                  cmd.out_load}))
        else $error("more than one datapath command at once");
`endif

endmodule

// ----- design/frn_dp.sv -----
// ----------------------------------------------------------------------------
// frn_dp: negotiator datapath
// Configuration registers, rate state, frame thinning accumulator, the ratio
// divider, the bitrate scaler and the output item register.
// ----------------------------------------------------------------------------
module frn_dp
    import frn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic [OUT_DATA_W-1:0] out_data,
    input  frn_cmd_t              cmd,
    output frn_status_t           status
);

    logic [1:0]           mode_reg;
    logic [7:0]           sb_reg;
    logic [BITRATE_W-1:0] cur_reg;

    logic [CLIENT_W-1:0]  client_reg;
    logic [RATE_W-1:0]    max_own_reg;
    logic [RATE_W-1:0]    ceil_reg;
    logic [RATE_W-1:0]    floor_reg;
    logic [MARGIN_W-1:0]  margin_reg;

    logic [RATE_W-1:0]    local_reg;
    logic [RATE_W-1:0]    remote_reg;
    logic [RATE_W-1:0]    cap_reg;
    logic [1:0]           fsl_reg;
    logic [COUNT_W-1:0]   fc_reg;
    logic [ACC_W-1:0]     acc_reg;

    logic [7:0]           sig_reg;
    logic                 upd_reg;
    logic                 keep_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic [26:0]          q_reg;
    logic                 scale_up_reg;
    logic [BITRATE_W-1:0] nbr_reg;

    logic [7:0]           b;
    logic                 bnz;
    logic                 force_bit;
    logic [1:0]           change;
    logic [RATE_W-1:0]    opp;
    logic [RATE_W-1:0]    cap_next;
    logic [RATE_W-1:0]    l1;
    logic [RATE_W-1:0]    local_next;
    logic                 up1;
    logic                 up2;
    logic                 rx_upd;

    logic [CLIENT_W:0]    own_sum;
    logic [CLIENT_W-1:0]  diff_q;
    logic                 keep_early;
    logic [CLIENT_W:0]    round_sum;
    logic [RATE_W+2:0]    rounded;

    logic [DIVD_W-1:0]    dividend;
    logic [DIVS_W-1:0]    divisor;
    logic                 div_start;
    logic [DIVD_W-1:0]    quotient;
    logic                 div_done;
    logic [ACC_W-1:0]     ratio;
    logic [ACC_W:0]       idx_sum;
    logic [COUNT_W:0]     idx;
    logic [COUNT_W-1:0]   fc_inc;

    logic [58:0]          q_prod;
    logic [4:0]           rem20;
    logic [8:0]           rem_k;
    logic [17:0]          frac_prod;
    logic [31:0]          nbr_sum;
    logic [BITRATE_W-1:0] nbr;

    assign b         = sb_reg & 8'hEF;
    assign bnz       = (b != 8'd0);
    assign force_bit = b[5];
    assign change    = b[7:6];
    assign opp       = b[3:0];
    assign cap_next  = (force_bit && ceil_reg >= opp) ? opp : cap_reg;
    assign l1        = (force_bit && local_reg > cap_next) ? cap_next : local_reg;
    assign up1       = (change == CHANGE_DOWN) && (l1 > floor_reg);
    assign up2       = (change == CHANGE_UP) && (l1 < ceil_reg) && (l1 < cap_next)
                     && ({1'b0, l1, 8'b0, 2'b00} >> 2 < {1'b0, client_reg} + TENTH_Q);
    assign rx_upd    = bnz && (up1 || up2);
    assign local_next = ({2'b00, l1, 8'b0} > client_reg) ? client_reg[11:8] : l1;

    assign own_sum    = {3'b000, local_reg, 8'b0} + {7'b0, margin_reg};
    assign diff_q     = client_reg - {2'b00, local_reg, 8'b0};
    assign keep_early = (own_sum > {1'b0, client_reg}) || (diff_q == '0);
    assign round_sum  = {1'b0, client_reg} + (CLIENT_W+1)'(1 << (FRAC_BITS - 1));
    assign rounded    = round_sum[CLIENT_W:FRAC_BITS];

    // bitrate * k / 20 as q * k + (r * k) / 20, with q = (bitrate / 4) / 5
    assign q_prod    = 59'(cur_reg[BITRATE_W-1:2]) * 59'(RECIP_FIVE);
    assign rem20     = cur_reg[4:0] - 5'({q_reg, 4'b0000} + {q_reg, 2'b00});
    assign rem_k     = 9'(rem20) * (scale_up_reg ? 9'd23 : 9'd17);
    assign frac_prod = 18'(rem_k) * 18'd205;
    assign nbr_sum   = 32'(q_reg) * (scale_up_reg ? 32'd23 : 32'd17)
                     + 32'(frac_prod[16:12]);
    assign nbr       = (nbr_sum > 32'(BITRATE_MAX)) ? BITRATE_MAX
                                                     : nbr_sum[BITRATE_W-1:0];

    assign dividend = {client_reg, 8'b0};
    assign divisor  = diff_q;

    always_comb
    begin
        status.div_done = div_done;
        unique case (mode_reg)
            MODE_FRAME: status.need_div = !keep_early;
            default:    status.need_div = 1'b0;
        endcase
    end

    assign div_start = cmd.exec && status.need_div;

    frn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign ratio   = ACC_W'(quotient);
    assign idx_sum = {1'b0, acc_reg} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
    assign idx     = idx_sum[ACC_W:FRAC_BITS];
    assign fc_inc  = fc_reg + COUNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data[1:0];
            sb_reg   <= in_data[9:2];
            cur_reg  <= in_data[40:10];
        end
        if (cmd.exec)
        begin
            q_reg        <= q_prod[58:32];
            scale_up_reg <= up2;
        end
        if (cmd.scale)
        begin
            nbr_reg <= nbr;
        end
        if (cmd.out_load)
        begin
            out_reg <= {7'b0, remote_reg, local_reg, keep_reg,
                        upd_reg ? nbr_reg : {BITRATE_W{1'b0}}, upd_reg, sig_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_reg  <= CLIENT_RESET;
            max_own_reg <= 4'd15;
            ceil_reg    <= 4'd15;
            floor_reg   <= 4'd1;
            margin_reg  <= 8'd26;
            local_reg   <= RATE_W'(START_RATE);
            remote_reg  <= RATE_W'(START_RATE);
            cap_reg     <= 4'd15;
            fsl_reg     <= 2'd0;
            fc_reg      <= '0;
            acc_reg     <= '0;
            sig_reg     <= '0;
            upd_reg     <= 1'b0;
            keep_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_CLIENT_FPS: client_reg <= cfg_wdata;
                    REG_MAX_OWN:
                    begin
                        max_own_reg <= cfg_wdata[3:0];
                        fsl_reg     <= 2'd2;
                    end
                    REG_CEILING: ceil_reg   <= cfg_wdata[3:0];
                    REG_FLOOR:   floor_reg  <= cfg_wdata[3:0];
                    REG_MARGIN:  margin_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (cmd.exec)
            begin
                sig_reg  <= '0;
                upd_reg  <= 1'b0;
                keep_reg <= 1'b0;
                unique case (mode_reg)
                    MODE_RECEIVE:
                    begin
                        if (bnz)
                        begin
                            cap_reg   <= cap_next;
                            local_reg <= local_next;
                            if (!force_bit)
                            begin
                                remote_reg <= opp;
                            end
                            upd_reg <= rx_upd;
                        end
                    end
                    MODE_BUILD:
                    begin
                        if (fsl_reg != 2'd0)
                        begin
                            fsl_reg <= fsl_reg - 2'd1;
                            sig_reg <= {4'b0010, max_own_reg};
                        end
                        else if (client_reg < {2'b00, ceil_reg, 8'b0}
                                 && {3'b000, local_reg} > rounded)
                        begin
                            sig_reg <= {1'b0, rounded};
                        end
                        else
                        begin
                            sig_reg <= {4'b0000, local_reg};
                        end
                    end
                    MODE_FRAME:
                    begin
                        keep_reg <= keep_early;
                    end
                    MODE_RESET:
                    begin
                        local_reg  <= RATE_W'(START_RATE);
                        remote_reg <= RATE_W'(START_RATE);
                        client_reg <= CLIENT_RESET;
                        fc_reg     <= '0;
                        acc_reg    <= '0;
                    end
                    default: ;
                endcase
            end
            if (cmd.fc_first && fc_reg == '0)
            begin
                acc_reg <= acc_reg + ratio;
            end
            if (cmd.fc_index)
            begin
                fc_reg <= fc_inc;
                if ({1'b0, fc_inc} == idx)
                begin
                    acc_reg  <= acc_reg + ratio;
                    keep_reg <= 1'b0;
                end
                else
                begin
                    keep_reg <= 1'b1;
                end
            end
        end
    end

    assign out_data = out_reg;

`ifndef NO_ASSERTIONS
    a_div_only_when_needed: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (mode_reg == MODE_RECEIVE || mode_reg == MODE_FRAME))
        else $error("divider started for a mode without a divide");
    a_frame_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (div_start && mode_reg == MODE_FRAME) |-> diff_q != '0)
        else $error("frame ratio started with zero divisor");
    a_fc_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fc_index |=> fc_reg == $past(fc_inc))
        else $error("frame count did not advance");
`endif

endmodule

// ----- design/frame_rate_negotiator.sv -----
// ----------------------------------------------------------------------------
// frame_rate_negotiator: frame rate negotiation and frame thinning
// One item in, one item out, one item in flight. Receive, build and soft
// reset items, and frame checks that keep at once, pass through execute,
// bitrate scale and output load. A frame check that needs its drop ratio
// runs the one-bit-per-cycle divider over the 22-bit scaled client rate,
// then the frame index phases before output load; the divider sets the
// worst-case rate. The bitrate x0.85 and x1.15 scaling uses a reciprocal
// multiplication registered in the execute and scale phases. A new item
// is accepted the cycle after the output register is loaded, while that
// item may still wait to be taken; a stalled output holds the block in
// its final phase. No clearing pass after reset.
// ----------------------------------------------------------------------------
module frame_rate_negotiator
    import frn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // mode, signal_byte, current_bitrate
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // signal_out, bitrate_update,
                                                 // new_bitrate, frame_keep,
                                                 // own_rate, peer_rate
);

    frn_cmd_t    cmd;
    frn_status_t status;

    frn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    frn_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
